// ===== rtl/life_automaton_torus_grid_top_assert.svh =====
// Assertion macros for the torus life grid, empty when synthesized.
`ifndef LIFE_AUTOMATON_TORUS_GRID_TOP_ASSERT_SVH
`define LIFE_AUTOMATON_TORUS_GRID_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define LIFE_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define LIFE_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define LIFE_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg)
`define LIFE_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif
`endif

// ===== rtl/life_pkg.sv =====
// Shared types and codes for the torus life grid.
`default_nettype none
package life_pkg;

    // Operation codes of a request.
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_TOGGLE = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_STEP   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // Rule constants: birth count and the survival count other than the birth count.
    localparam logic [3:0] CNT_BIRTH = 4'd3;
    localparam logic [3:0] CNT_KEEP  = 4'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic       cell_value;
    } t_req;

    typedef struct packed {
        logic       cell_state;
        logic [2:0] done_op;
    } t_rsp;

    // Commands from the controller to the datapath, one per cycle.
    typedef enum logic [3:0] {
        C_NONE,
        C_LATCH,
        C_CELL_RD,
        C_CELL_FIN,
        C_CLEAR,
        C_NOP_FIN,
        C_ST_RD_LAST,
        C_ST_RD_FIRST,
        C_ST_RD_SECOND,
        C_ST_CAP,
        C_ST_CELL,
        C_ST_WR,
        C_ST_NEXT,
        C_ST_FIN
    } t_cmd;

    // Status from the datapath's scan counters.
    typedef struct packed {
        logic x_last;
        logic y_last;
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CELL_RD,
        S_CELL_FIN,
        S_CLEAR,
        S_NOP,
        S_ST_R0,
        S_ST_R1,
        S_ST_R2,
        S_ST_R3,
        S_ST_CELL,
        S_ST_WR,
        S_ST_NX,
        S_ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/life_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module life_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 18
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/life_ctrl.sv =====
// Controller state machine that sequences cell operations and generation steps.
`default_nettype none
module life_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic [2:0]       i_op,
    input  wire life_pkg::t_status i_status,
    output logic                  busy,
    output life_pkg::t_cmd        o_cmd
);
    import life_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_op) inside
                        OP_WRITE, OP_TOGGLE, OP_READ: n_state = S_CELL_RD;
                        OP_CLEAR:                     n_state = S_CLEAR;
                        OP_STEP:                      n_state = S_ST_R0;
                        default:                      n_state = S_NOP;
                    endcase
                end
            end
            S_CELL_RD:  n_state = S_CELL_FIN;
            S_CELL_FIN: n_state = S_IDLE;
            S_CLEAR:    n_state = S_IDLE;
            S_NOP:      n_state = S_IDLE;
            S_ST_R0:    n_state = S_ST_R1;
            S_ST_R1:    n_state = S_ST_R2;
            S_ST_R2:    n_state = S_ST_R3;
            S_ST_R3:    n_state = S_ST_CELL;
            S_ST_CELL: begin
                if (i_status.x_last) begin
                    n_state = S_ST_WR;
                end
            end
            S_ST_WR:    n_state = i_status.y_last ? S_ST_DONE : S_ST_NX;
            S_ST_NX:    n_state = S_ST_CELL;
            S_ST_DONE:  n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Command and handshake outputs.
    always_comb begin
        busy  = (r_state != S_IDLE);
        o_cmd = C_NONE;
        unique case (r_state)
            S_IDLE:     o_cmd = start ? C_LATCH : C_NONE;
            S_CELL_RD:  o_cmd = C_CELL_RD;
            S_CELL_FIN: o_cmd = C_CELL_FIN;
            S_CLEAR:    o_cmd = C_CLEAR;
            S_NOP:      o_cmd = C_NOP_FIN;
            S_ST_R0:    o_cmd = C_ST_RD_LAST;
            S_ST_R1:    o_cmd = C_ST_RD_FIRST;
            S_ST_R2:    o_cmd = C_ST_RD_SECOND;
            S_ST_R3:    o_cmd = C_ST_CAP;
            S_ST_CELL:  o_cmd = C_ST_CELL;
            S_ST_WR:    o_cmd = C_ST_WR;
            S_ST_NX:    o_cmd = C_ST_NEXT;
            S_ST_DONE:  o_cmd = C_ST_FIN;
            default:    o_cmd = C_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/life_dp.sv =====
// Datapath: row memory, row valid bits, line buffers and the neighbor counter.
`default_nettype none
module life_dp #(
    parameter int GRID_WIDTH  = 20,
    parameter int GRID_HEIGHT = 18
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire life_pkg::t_cmd   i_cmd,
    input  wire life_pkg::t_req   i_req,
    output life_pkg::t_status     o_status,
    output logic                  o_strobe,
    output life_pkg::t_rsp        o_rsp
);
    import life_pkg::*;

    localparam int XW = $clog2(GRID_WIDTH);
    localparam int AW = $clog2(GRID_HEIGHT);

    t_req                  r_req;
    logic [GRID_HEIGHT-1:0] r_valid;
    logic                  r_vld_q;
    logic [GRID_WIDTH-1:0] r_prev;
    logic [GRID_WIDTH-1:0] r_cur;
    logic [GRID_WIDTH-1:0] r_next;
    logic [GRID_WIDTH-1:0] r_row0;
    logic [GRID_WIDTH-1:0] r_new;
    logic [XW-1:0]         r_x;
    logic [AW-1:0]         r_y;
    logic                  r_strobe;
    t_rsp                  r_rsp;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [GRID_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [GRID_WIDTH-1:0] ram_rdata;
    logic [GRID_WIDTH-1:0] row_rd;

    logic                  on_grid;
    logic [XW-1:0]         req_x;
    logic [AW-1:0]         req_y;
    logic                  old_bit;
    logic                  cell_bit;
    logic [GRID_WIDTH-1:0] cell_row;
    logic [AW:0]           y_plus2;
    logic                  y2_on_grid;
    logic [XW-1:0]         xm;
    logic [XW-1:0]         xp;
    logic [7:0]            nbrs;
    logic [3:0]            cnt;
    logic                  life_bit;

    life_ram #(
        .WIDTH (GRID_WIDTH),
        .DEPTH (GRID_HEIGHT)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A row never written since reset or clear reads as all dead.
    assign row_rd = r_vld_q ? ram_rdata : '0;

    // Addressed cell of a single-cell request.
    assign on_grid = (32'(r_req.cell_x) < GRID_WIDTH) && (32'(r_req.cell_y) < GRID_HEIGHT);
    assign req_x   = XW'(r_req.cell_x);
    assign req_y   = AW'(r_req.cell_y);
    assign old_bit = row_rd[req_x];

    always_comb begin
        cell_row = row_rd;
        case (r_req.op)
            OP_WRITE:  cell_bit = r_req.cell_value;
            OP_TOGGLE: cell_bit = ~old_bit;
            default:   cell_bit = old_bit;
        endcase
        cell_row[req_x] = cell_bit;
    end

    // Row that follows the next one, for the line-buffer refill.
    assign y_plus2    = {1'b0, r_y} + (AW+1)'(2);
    assign y2_on_grid = (32'(y_plus2) < GRID_HEIGHT);

    // Wrapped neighbor columns and the B3/S23 rule for the scanned cell.
    assign xm = (r_x == '0) ? XW'(GRID_WIDTH - 1) : r_x - XW'(1);
    assign xp = (32'(r_x) == GRID_WIDTH - 1) ? '0 : r_x + XW'(1);
    assign nbrs = {r_prev[xm], r_prev[r_x], r_prev[xp], r_cur[xm], r_cur[xp],
                   r_next[xm], r_next[r_x], r_next[xp]};
    assign cnt      = 4'($countones(nbrs));
    assign life_bit = (cnt == CNT_BIRTH) || (r_cur[r_x] && (cnt == CNT_KEEP));

    assign o_status.x_last = (32'(r_x) == GRID_WIDTH - 1);
    assign o_status.y_last = (32'(r_y) == GRID_HEIGHT - 1);

    // Memory port control decoded from the command.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_y;
        ram_wdata = r_new;
        ram_raddr = '0;
        unique case (i_cmd)
            C_CELL_RD:      ram_raddr = req_y;
            C_CELL_FIN: begin
                ram_we    = on_grid && ((r_req.op == OP_WRITE) || (r_req.op == OP_TOGGLE));
                ram_waddr = req_y;
                ram_wdata = cell_row;
            end
            C_ST_RD_LAST:   ram_raddr = AW'(GRID_HEIGHT - 1);
            C_ST_RD_FIRST:  ram_raddr = '0;
            C_ST_RD_SECOND: ram_raddr = AW'(1);
            C_ST_WR: begin
                ram_we    = 1'b1;
                ram_raddr = y_plus2[AW-1:0];
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
    end

    // Control registers: row valid bits and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd == C_CELL_FIN) || (i_cmd == C_CLEAR) ||
                        (i_cmd == C_NOP_FIN) || (i_cmd == C_ST_FIN);
            if (i_cmd == C_CLEAR) begin
                r_valid <= '0;
            end else if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers: request, line buffers, scan counters and result.
    always_ff @(posedge i_clk) begin
        r_vld_q <= (32'(ram_raddr) < GRID_HEIGHT) ? r_valid[ram_raddr] : 1'b0;
        unique case (i_cmd)
            C_LATCH: begin
                r_req <= i_req;
            end
            C_CELL_FIN: begin
                r_rsp.cell_state <= on_grid ? cell_bit : 1'b0;
                r_rsp.done_op    <= r_req.op;
            end
            C_CLEAR, C_NOP_FIN, C_ST_FIN: begin
                r_rsp.cell_state <= 1'b0;
                r_rsp.done_op    <= r_req.op;
            end
            C_ST_RD_FIRST: begin
                r_prev <= row_rd;
            end
            C_ST_RD_SECOND: begin
                r_cur <= row_rd;
            end
            C_ST_CAP: begin
                r_next <= row_rd;
                r_row0 <= r_cur;
                r_x    <= '0;
                r_y    <= '0;
            end
            C_ST_CELL: begin
                r_new[r_x] <= life_bit;
                r_x        <= o_status.x_last ? '0 : r_x + XW'(1);
            end
            C_ST_WR: begin
                r_prev <= r_cur;
                r_cur  <= r_next;
            end
            C_ST_NEXT: begin
                r_next <= y2_on_grid ? row_rd : r_row0;
                r_y    <= r_y + AW'(1);
                r_x    <= '0;
            end
            default: begin
                r_x <= r_x;
            end
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule
`default_nettype wire

// ===== rtl/life_automaton_torus_grid_top.sv =====
// Top level of the toroidal B3/S23 life grid.
//
//  channel   direction  handshake            payload
//  request   in         start, busy          i_req  (op, cell_x, cell_y, cell_value)
//  result    out        o_strobe (one cycle) o_rsp  (cell_state, done_op)
//
// Write, toggle and read pass through a read state and a finish state before
// the result strobe; clear and unused codes use a single state. A generation
// step reads the grid, held one row per word in a single RAM, while the
// neighbor counter visits one cell per cycle along a row over three line
// buffers. Reset clears the row valid bits at once, so the grid reads as all
// dead with no clearing pass. The receiver cannot stall: each result shows
// for one cycle, while busy is already low.
`default_nettype none
`include "life_automaton_torus_grid_top_assert.svh"
module life_automaton_torus_grid_top #(
    parameter int GRID_WIDTH  = 20,
    parameter int GRID_HEIGHT = 18
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire life_pkg::t_req i_req,
    output logic                busy,
    output logic                o_strobe,
    output life_pkg::t_rsp      o_rsp
);
    import life_pkg::*;

    t_cmd    cmd;
    t_status status;

    life_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_op     (i_req.op),
        .i_status (status),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    life_dp #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_status (status),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    // A result only follows a cycle of work on a request.
    `LIFE_ASSERT_IMPLY(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(busy), "result without request")
    // An accepted request makes the block busy.
    `LIFE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, start && !busy, busy, "request not taken")
    // Clear and step always report a dead cell.
    `LIFE_ASSERT_IMPLY(a_step_state_zero, i_clk, i_rst_n, o_strobe && ((o_rsp.done_op == OP_STEP) || (o_rsp.done_op == OP_CLEAR)), !o_rsp.cell_state, "nonzero state on grid-wide operation")

endmodule
`default_nettype wire
